/* rtl/btf_pkg.sv */
// ----------------------------------------------------------------------------
// btf_pkg: shared types and constants of the BER-TLV tag finder
// Field widths, byte codes and the structs passed among the core, the parser
// and the level stack.
// ----------------------------------------------------------------------------
package btf_pkg;

   localparam int DEPTH_W       = 4;   // holds any nesting depth up to 15
   localparam int POS_W         = 17;
   localparam int LEN_W         = 16;
   localparam int TAG_W         = 32;
   localparam int BYTE_W        = 8;
   localparam int MAX_DEPTH_DEF = 8;

   // item kinds
   localparam logic ACT_START = 1'b0;
   localparam logic ACT_BYTE  = 1'b1;

   // BER-TLV byte codes
   localparam logic [BYTE_W-1:0] TAG_NUM_MASK = 8'h1F;
   localparam logic [BYTE_W-1:0] LEN_LONG_BIT = 8'h80;
   localparam logic [BYTE_W-1:0] LEN_CNT_MASK = 8'h7F;
   localparam logic [BYTE_W-1:0] CONSTR_BIT   = 8'h20;
   localparam logic [BYTE_W-1:0] PAD_ZERO     = 8'h00;
   localparam logic [BYTE_W-1:0] PAD_ONES     = 8'hFF;

   typedef struct packed {
      logic              action;
      logic [TAG_W-1:0]  target_tag;
      logic [LEN_W-1:0]  buffer_length;
      logic [BYTE_W-1:0] data_byte;
   } item_type;

   typedef struct packed {
      logic               we;
      logic [DEPTH_W-1:0] waddr;
      logic [POS_W-1:0]   wdata;
      logic [DEPTH_W-1:0] chk_depth;
      logic [POS_W-1:0]   chk_pos;
   } stk_req_type;

   typedef struct packed {
      logic               keep;        // some open level does not end here
      logic [DEPTH_W-1:0] keep_depth;  // deepest such level
   } stk_rsp_type;

   typedef struct packed {
      logic             valid;
      logic             found;
      logic [LEN_W-1:0] offset;
      logic [LEN_W-1:0] length;
   } result_type;

endpackage

/* rtl/ber_tlv_tag_finder_core.sv */
// ----------------------------------------------------------------------------
// ber_tlv_tag_finder_core: streamed BER-TLV tag search
// Input item register, parser, level stack and result register.
// ----------------------------------------------------------------------------
// Usage:
//  - req_ channel: an item with req_action = 0 starts a search for
//    req_target_tag over a buffer of req_buffer_length bytes; items with
//    req_action = 1 then carry the buffer bytes in req_data_byte, in order.
//  - rsp_ channel: one item per search, found with the value's offset and
//    length, or not found (offset and length zero). An empty buffer gives
//    its not-found item right from the start item.
//  - Path: the deciding item is held in the input register, and its result
//    is then loaded into the result register that drives rsp_valid.
//  - Throughput: one item per cycle unless an item that gives a result waits
//    on a busy output (see Stall). The per-byte work is the header decode
//    plus one end compare per open level, all done within the parse step.
//  - Stall: while a result waits on rsp_ready, items that give no result
//    keep flowing; an item that would give a second result waits in the
//    input register until the waiting result is taken (it may step in the
//    same cycle that rsp_ready takes the old one).
//  - Reset: clears the channels and leaves no search active; bytes that
//    arrive with no search active are taken and dropped.
// ----------------------------------------------------------------------------
module ber_tlv_tag_finder_core #(
   parameter int MAX_DEPTH = btf_pkg::MAX_DEPTH_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_action,
   input  logic [btf_pkg::TAG_W-1:0]    req_target_tag,
   input  logic [btf_pkg::LEN_W-1:0]    req_buffer_length,
   input  logic [btf_pkg::BYTE_W-1:0]   req_data_byte,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic                         rsp_found,
   output logic [btf_pkg::LEN_W-1:0]    rsp_value_offset,
   output logic [btf_pkg::LEN_W-1:0]    rsp_value_length
);
   import btf_pkg::*;

   logic               in_v_ff, in_v_in;
   item_type           in_item_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   result_type         rsp_res_ff;
   logic               step_en;
   result_type         res;
   stk_req_type        stk_req;
   stk_rsp_type        stk_rsp;
   logic [DEPTH_W-1:0] rd_depth;
   logic [POS_W-1:0]   cur_end;

   // the held item steps unless it makes a result while one is still waiting
   assign step_en   = in_v_ff && !(res.valid && rsp_valid_ff && !rsp_ready);
   assign req_ready = !in_v_ff || step_en;

   always_comb begin
      in_v_in = in_v_ff;
      if (req_valid && req_ready) begin
         in_v_in = 1'b1;
      end else if (step_en) begin
         in_v_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (step_en && res.valid) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_v_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_v_ff      <= in_v_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_item_ff.action        <= req_action;
         in_item_ff.target_tag    <= req_target_tag;
         in_item_ff.buffer_length <= req_buffer_length;
         in_item_ff.data_byte     <= req_data_byte;
      end
      if (step_en && res.valid) begin
         rsp_res_ff <= res;
      end
   end

   btf_parser #(.MAX_DEPTH(MAX_DEPTH)) u_parser (
      .clock   (clock),
      .reset   (reset),
      .step_en (step_en),
      .item    (in_item_ff),
      .cur_end (cur_end),
      .stk_rsp (stk_rsp),
      .stk_req (stk_req),
      .rd_depth(rd_depth),
      .res     (res)
   );

   btf_level_stack #(.MAX_DEPTH(MAX_DEPTH)) u_stack (
      .clock   (clock),
      .step_en (step_en),
      .stk_req (stk_req),
      .rd_depth(rd_depth),
      .cur_end (cur_end),
      .stk_rsp (stk_rsp)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_found        = rsp_res_ff.found;
   assign rsp_value_offset = rsp_res_ff.offset;
   assign rsp_value_length = rsp_res_ff.length;

   a_hold_on_busy: assert property (@(posedge clock) disable iff (reset)
      (in_v_ff && res.valid && rsp_valid_ff && !rsp_ready) |=>
         in_v_ff && $stable(in_item_ff))
      else $error("item with a result dropped while output busy");

   a_result_loaded: assert property (@(posedge clock) disable iff (reset)
      (step_en && res.valid) |=> rsp_valid_ff)
      else $error("result lost on the way to the output register");

endmodule

/* rtl/btf_level_stack.sv */
// ----------------------------------------------------------------------------
// btf_level_stack: end offsets of the open nesting levels
// At most one write per item; per-level compares against the new position find the
// deepest level that stays open.
// ----------------------------------------------------------------------------
module btf_level_stack #(
   parameter int MAX_DEPTH = btf_pkg::MAX_DEPTH_DEF
) (
   input  logic                         clock,
   input  logic                         step_en,
   input  btf_pkg::stk_req_type         stk_req,
   input  logic [btf_pkg::DEPTH_W-1:0]  rd_depth,
   output logic [btf_pkg::POS_W-1:0]    cur_end,
   output btf_pkg::stk_rsp_type         stk_rsp
);
   import btf_pkg::*;

   localparam int NUM_LVL = MAX_DEPTH + 1;
   localparam int IDX_W   = $clog2(NUM_LVL);

   logic [POS_W-1:0]   lvl_end_ff [NUM_LVL];
   logic [POS_W-1:0]   eff_end    [NUM_LVL];
   logic [NUM_LVL-1:0] open_ne;

   // write only when the item really steps
   always_ff @(posedge clock) begin
      if (step_en && stk_req.we) begin
         lvl_end_ff[stk_req.waddr[IDX_W-1:0]] <= stk_req.wdata;
      end
   end

   assign cur_end = lvl_end_ff[rd_depth[IDX_W-1:0]];

   // a level written by this item is compared with its new end
   always_comb begin
      for (int k = 0; k < NUM_LVL; k++) begin
         eff_end[k] = (stk_req.we && stk_req.waddr == DEPTH_W'(k)) ? stk_req.wdata
                                                                  : lvl_end_ff[k];
         open_ne[k] = (eff_end[k] != stk_req.chk_pos) &&
                      (DEPTH_W'(k) <= stk_req.chk_depth);
      end
   end

   always_comb begin
      stk_rsp = '0;
      for (int k = 0; k < NUM_LVL; k++) begin
         if (open_ne[k]) begin
            stk_rsp.keep       = 1'b1;
            stk_rsp.keep_depth = DEPTH_W'(k);
         end
      end
   end

endmodule

/* rtl/btf_parser.sv */
// ----------------------------------------------------------------------------
// btf_parser: per-byte BER-TLV parse state and result decision
// Takes one item per enabled cycle: header decode, then level-end unwinding.
// ----------------------------------------------------------------------------
module btf_parser #(
   parameter int MAX_DEPTH = btf_pkg::MAX_DEPTH_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         step_en,
   input  btf_pkg::item_type            item,
   input  logic [btf_pkg::POS_W-1:0]    cur_end,
   input  btf_pkg::stk_rsp_type         stk_rsp,
   output btf_pkg::stk_req_type         stk_req,
   output logic [btf_pkg::DEPTH_W-1:0]  rd_depth,
   output btf_pkg::result_type          res
);
   import btf_pkg::*;

   typedef enum logic [2:0] {
      PH_IDLE, PH_OBJ, PH_TAG, PH_LEN1, PH_LENN, PH_SKIP, PH_FAULT
   } phase_type;

   phase_type          phase_ff, phase_in, s_phase;
   logic [TAG_W-1:0]   sought_ff, sought_in, s_sought;
   logic [POS_W-1:0]   pos_ff, pos_in, s_pos;
   logic [DEPTH_W-1:0] depth_ff, depth_in, s_depth;
   logic [TAG_W-1:0]   tag_ff, tag_in, s_tag;
   logic               cons_ff, cons_in, s_cons;
   logic [1:0]         lbl_ff, lbl_in, s_lbl;
   logic [LEN_W-1:0]   lacc_ff, lacc_in, s_lacc;
   result_type         s_res;

   logic               hdr_go, flt_go, at_end;
   logic [LEN_W-1:0]   hdr_len;
   logic [POS_W:0]     end_sum;
   logic [BYTE_W-1:0]  b, lcnt;

   assign b        = item.data_byte;
   assign lcnt     = item.data_byte & LEN_CNT_MASK;
   assign rd_depth = depth_ff;

   // start items, byte decode and header completion
   always_comb begin
      s_sought = sought_ff;
      s_pos    = pos_ff;
      s_depth  = depth_ff;
      s_phase  = phase_ff;
      s_tag    = tag_ff;
      s_cons   = cons_ff;
      s_lbl    = lbl_ff;
      s_lacc   = lacc_ff;
      s_res    = '0;
      stk_req  = '0;
      hdr_go   = 1'b0;
      hdr_len  = '0;
      flt_go   = 1'b0;
      end_sum  = '0;
      if (item.action == ACT_START) begin
         s_sought      = item.target_tag;
         s_pos         = '0;
         s_depth       = '0;
         s_phase       = PH_OBJ;
         s_tag         = '0;
         s_cons        = 1'b0;
         s_lbl         = '0;
         s_lacc        = '0;
         stk_req.we    = 1'b1;
         stk_req.waddr = '0;
         stk_req.wdata = {1'b0, item.buffer_length};
      end else if (phase_ff != PH_IDLE) begin
         s_pos = pos_ff + 1'b1;
         case (phase_ff)
            PH_OBJ: begin
               if (!(b inside {PAD_ZERO, PAD_ONES})) begin
                  s_tag   = {{(TAG_W-BYTE_W){1'b0}}, b};
                  s_cons  = (b & CONSTR_BIT) != '0;
                  s_phase = ((b & TAG_NUM_MASK) == TAG_NUM_MASK) ? PH_TAG : PH_LEN1;
               end
            end
            PH_TAG: begin
               s_tag = {tag_ff[TAG_W-BYTE_W-1:0], b};
               if ((b & LEN_LONG_BIT) == '0) begin
                  s_phase = PH_LEN1;
               end
            end
            PH_LEN1: begin
               if ((b & LEN_LONG_BIT) == '0) begin
                  hdr_go  = 1'b1;
                  hdr_len = {{(LEN_W-BYTE_W){1'b0}}, b};
               end else if (lcnt == '0 || lcnt > 8'd2) begin
                  flt_go = 1'b1;
               end else begin
                  s_lbl   = lcnt[1:0];
                  s_lacc  = '0;
                  s_phase = PH_LENN;
               end
            end
            PH_LENN: begin
               s_lacc = {lacc_ff[LEN_W-BYTE_W-1:0], b};
               s_lbl  = lbl_ff - 1'b1;
               if (s_lbl == 2'd0) begin
                  hdr_go  = 1'b1;
                  hdr_len = s_lacc;
               end
            end
            PH_SKIP: begin
               s_lacc = lacc_ff - 1'b1;
               if (s_lacc == '0) begin
                  s_phase = PH_OBJ;
               end
            end
            default: begin
            end
         endcase
         end_sum = {1'b0, s_pos} + {{(POS_W+1-LEN_W){1'b0}}, hdr_len};
         if (hdr_go) begin
            if (end_sum > {1'b0, cur_end}) begin
               flt_go = 1'b1;
            end else if (tag_ff == sought_ff) begin
               s_phase      = PH_IDLE;
               s_res.valid  = 1'b1;
               s_res.found  = 1'b1;
               s_res.offset = s_pos[LEN_W-1:0];
               s_res.length = hdr_len;
            end else if (cons_ff && depth_ff < DEPTH_W'(MAX_DEPTH)) begin
               s_depth       = depth_ff + 1'b1;
               s_phase       = PH_OBJ;
               stk_req.we    = 1'b1;
               stk_req.waddr = depth_ff + 1'b1;
               stk_req.wdata = end_sum[POS_W-1:0];
            end else if (hdr_len != '0) begin
               s_lacc  = hdr_len;
               s_phase = PH_SKIP;
            end else begin
               s_phase = PH_OBJ;
            end
         end
         if (flt_go) begin
            if (depth_ff == '0) begin
               s_phase     = PH_IDLE;
               s_res.valid = 1'b1;
            end else begin
               s_phase = PH_FAULT;
            end
         end
      end
      stk_req.chk_pos   = s_pos;
      stk_req.chk_depth = s_depth;
   end

   // level ends reached at the new position: unwind to the deepest open level, or end the search not found if none
   always_comb begin
      sought_in = s_sought;
      pos_in    = s_pos;
      depth_in  = s_depth;
      phase_in  = s_phase;
      tag_in    = s_tag;
      cons_in   = s_cons;
      lbl_in    = s_lbl;
      lacc_in   = s_lacc;
      res       = s_res;
      at_end    = !(stk_rsp.keep && stk_rsp.keep_depth == s_depth);
      if (at_end && (s_phase inside {PH_OBJ, PH_FAULT, PH_TAG, PH_LEN1, PH_LENN})) begin
         if (((s_phase inside {PH_TAG, PH_LEN1, PH_LENN}) && s_depth == '0) ||
             !stk_rsp.keep) begin
            phase_in  = PH_IDLE;
            res       = '0;
            res.valid = 1'b1;
         end else begin
            depth_in = stk_rsp.keep_depth;
            phase_in = PH_OBJ;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         sought_ff <= '0;
         pos_ff    <= '0;
         depth_ff  <= '0;
         tag_ff    <= '0;
         cons_ff   <= 1'b0;
         lbl_ff    <= '0;
         lacc_ff   <= '0;
      end else if (step_en) begin
         phase_ff  <= phase_in;
         sought_ff <= sought_in;
         pos_ff    <= pos_in;
         depth_ff  <= depth_in;
         tag_ff    <= tag_in;
         cons_ff   <= cons_in;
         lbl_ff    <= lbl_in;
         lacc_ff   <= lacc_in;
      end
   end

   a_depth_range: assert property (@(posedge clock) disable iff (reset)
      depth_ff <= DEPTH_W'(MAX_DEPTH))
      else $error("nesting depth beyond limit");

   a_idle_byte: assert property (@(posedge clock) disable iff (reset)
      (step_en && item.action == ACT_BYTE && phase_ff == PH_IDLE) |=>
         (phase_ff == PH_IDLE) && $stable(pos_ff))
      else $error("byte changed state with no search active");

   a_result_ends: assert property (@(posedge clock) disable iff (reset)
      (step_en && res.valid) |=> phase_ff == PH_IDLE)
      else $error("search still active after its result");

endmodule
